// ===== src/moving_average_filter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// moving_average_filter_unit_macros
// assertion macros used by the moving average filter unit
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_FILTER_UNIT_MACROS_SVH
`define MOVING_AVERAGE_FILTER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MAF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define MAF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/maf_pkg.sv =====
// ----------------------------------------------------------------------------
// maf_pkg
// types and constants of the boxcar moving average filter
// ----------------------------------------------------------------------------
`default_nettype none

package maf_pkg;

    localparam int SAMPLE_W       = 18;
    localparam int DEFAULT_WINDOW = 8;

    typedef enum logic {
        REQ_UPDATE = 1'b0,
        REQ_CLEAR  = 1'b1
    } t_req_type;

    typedef struct packed {
        t_req_type             req_type;
        logic [SAMPLE_W-1:0]   sample_value;
    } t_in_req;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   average;
    } t_out_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RMW,
        S_DIV,
        S_HOLD
    } t_state;

endpackage

`default_nettype wire

// ===== src/maf_stream_if.sv =====
// ----------------------------------------------------------------------------
// maf_stream_if
// valid / ready request channel with a typed payload
// ----------------------------------------------------------------------------
`default_nettype none

interface maf_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/maf_ring_ram.sv =====
// ----------------------------------------------------------------------------
// maf_ring_ram
// sample ring, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module maf_ring_ram #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3,
    parameter int DATA_W = 18
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/maf_divider.sv =====
// ----------------------------------------------------------------------------
// maf_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module maf_divider #(
    parameter int DIVIDEND_W = 21,
    parameter int DIVISOR_W  = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic      [DIVIDEND_W-1:0] o_quotient
);

    localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  r_busy,  n_busy;
    logic                  r_done,  n_done;
    logic [STEP_W-1:0]     r_step,  n_step;
    logic [DIVIDEND_W-1:0] r_quo,   n_quo;
    logic [DIVISOR_W-1:0]  r_rem,   n_rem;
    logic [DIVISOR_W-1:0]  r_div,   n_div;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    always_comb begin
        trial  = {r_rem, r_quo[DIVIDEND_W-1]};
        diff   = trial - {1'b0, r_div};
        ge     = (trial >= {1'b0, r_div});
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            n_quo  = {r_quo[DIVIDEND_W-2:0], ge};
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(DIVIDEND_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== src/moving_average_filter_unit.sv =====
// ----------------------------------------------------------------------------
// moving_average_filter_unit
// boxcar moving average over the last WINDOW samples
//
//   port    dir   payload                      request
//   i_in    in    req_type, sample_value       update or clear
//   o_out   out   average                      one per update
//
// an update passes through accept, a read-modify-write on the ring, the
// divider (SUM_W quotient bits, one each step) and an output load. a clear
// takes effect when accepted and gives no result.
// reset (synchronous, active low) zeroes sum, position and fill count; ring
// entries at or beyond the fill count read as zero, so no clearing pass.
// a finished average waits in the output register while the next request
// is taken; the divider holds its quotient if that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_filter_unit #(
    parameter int WINDOW = maf_pkg::DEFAULT_WINDOW
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    maf_stream_if.sink   i_in,
    maf_stream_if.source o_out
);

    import maf_pkg::*;

    `include "moving_average_filter_unit_macros.svh"

    localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

    t_state                r_state, n_state;
    logic [POS_W-1:0]      r_pos,   n_pos;
    logic [CNT_W-1:0]      r_cnt,   n_cnt;
    logic [SUM_W-1:0]      r_sum,   n_sum;
    logic [SAMPLE_W-1:0]   r_sample, n_sample;
    logic                  r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0]   r_avg,   n_avg;

    logic                  in_acc;
    logic                  out_free;
    logic                  ram_we;
    logic                  ram_re;
    logic [SAMPLE_W-1:0]   ram_rdata;
    logic [SAMPLE_W-1:0]   old_sample;
    logic                  div_start;
    logic                  div_done;
    logic [SUM_W-1:0]      div_quo;
    t_in_req               in_req;

    assign in_req   = i_in.payload;
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    maf_ring_ram #(
        .DEPTH  (WINDOW),
        .ADDR_W (POS_W),
        .DATA_W (SAMPLE_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata (r_sample),
        .i_re    (ram_re),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    maf_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_cnt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_avg    <= n_avg;
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_sample    = r_sample;
        n_avg       = r_avg;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        div_start   = 1'b0;
        old_sample  = (CNT_W'(r_pos) < r_cnt) ? ram_rdata : '0;
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (in_req.req_type == REQ_CLEAR) begin
                        n_pos = '0;
                        n_cnt = '0;
                        n_sum = '0;
                    end else begin
                        n_sample = in_req.sample_value;
                        ram_re   = 1'b1;
                        n_state  = S_RMW;
                    end
                end
            end
            S_RMW: begin
                // ring entries at or beyond the fill count read as zero
                n_sum     = r_sum - SUM_W'(old_sample) + SUM_W'(r_sample);
                ram_we    = 1'b1;
                n_pos     = (r_pos == POS_W'(WINDOW - 1)) ? '0 : r_pos + 1'b1;
                n_cnt     = (r_cnt < CNT_W'(WINDOW)) ? r_cnt + 1'b1 : r_cnt;
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    if (out_free) begin
                        n_avg       = div_quo[SAMPLE_W-1:0];
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_avg       = div_quo[SAMPLE_W-1:0];
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.payload.average = r_avg;

    `MAF_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(WINDOW),
        "fill count beyond window")
    `MAF_ASSERT_IMPL(a_pos_range, i_clk, i_rst_n, 1'b1, CNT_W'(r_pos) < CNT_W'(WINDOW),
        "ring position beyond window")
    `MAF_ASSERT_IMPL(a_empty_sum, i_clk, i_rst_n, r_cnt == '0, r_sum == '0,
        "sum not zero with empty ring")
    `MAF_ASSERT_NEXT(a_div_result, i_clk, i_rst_n, (r_state == S_DIV) && div_done,
        r_out_valid, "divider result not held in output register")

endmodule

`default_nettype wire
